// File: hdl/event_timer_table_top_macros.svh
// Assertion macros shared by the event timer table modules
`ifndef EVENT_TIMER_TABLE_TOP_MACROS_SVH
`define EVENT_TIMER_TABLE_TOP_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define ETT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define ETT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ett_pkg.sv
`timescale 1ns / 1ps
package ett_pkg;
    localparam int unsigned EVENT_SLOTS_DEF    = 16;
    localparam int unsigned TICK_PERIOD_US_DEF = 1000;
    localparam int unsigned ID_SHIFT           = 12;
    localparam int unsigned TICK_W             = 20;
    localparam logic [31:0] ID_SLOT_MASK       = 32'h0000_0fff;
    localparam logic [31:0] MS_PER_TICK_BASE   = 32'd1000;

    typedef enum logic [2:0] {
        OP_CREATE_UNIQUE = 3'd0,
        OP_CREATE_NEW    = 3'd1,
        OP_CLEAN_HANDLE  = 3'd2,
        OP_SEARCH_ID     = 3'd3,
        OP_RESET_ID      = 3'd4,
        OP_CLEAN_ID      = 3'd5,
        OP_TICK          = 3'd6,
        OP_DISPATCH      = 3'd7
    } t_opcode;

    typedef struct packed {
        logic        ok;
        logic        fired;
        logic [31:0] id;
        logic [31:0] handle;
        logic [31:0] param;
        logic        last;
    } t_result;
endpackage

// File: hdl/event_timer_table_top.sv
`timescale 1ns / 1ps
// Event timer table.
// Input channel: i_valid / o_stall with opcode, delay_ms, handle, user_param
// and event_id. A transfer happens on a rising edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carries ok, fired, out_id,
// out_handle, out_param and last; a transfer happens with o_valid high and
// i_stall low.
// One item at a time: o_stall stays high from the transfer of an item
// until its last result has been taken. Each command walks all slots with
// one shared compare unit, one slot per cycle while no dispatch result
// waits in S_EMIT. The walk in S_SCAN is followed by S_APPLY, which
// registers the result, then S_OUT, which hands it over, and the block is
// back in S_IDLE once that result has been taken.
// Create ops add the delay conversion in S_CONV before the walk, with a
// reciprocal multiply when TICK_PERIOD_US exceeds 1000. Dispatch gives one
// result per expired slot, each held in S_EMIT, plus a closing one.
// Reset (synchronous, active low) empties every slot through per-slot
// valid bits and clears the tick counter; the block is ready the next cycle.
// A stalled result holds on the port; the walk waits until it is taken.
module event_timer_table_top #(
    parameter int unsigned EVENT_SLOTS    = ett_pkg::EVENT_SLOTS_DEF,
    parameter int unsigned TICK_PERIOD_US = ett_pkg::TICK_PERIOD_US_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_handle,
    input  logic [31:0] i_user_param,
    input  logic [31:0] i_event_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic        o_fired,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_handle,
    output logic [31:0] o_out_param,
    output logic        o_last
);
    import ett_pkg::*;

    localparam int unsigned IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int unsigned CW = $clog2(EVENT_SLOTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(EVENT_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_SCAN, S_APPLY, S_EMIT, S_OUT
    } t_state;

    t_state r_state;
    logic [EVENT_SLOTS-1:0] r_used;
    logic [31:0] r_handle [EVENT_SLOTS];
    logic [31:0] r_ident  [EVENT_SLOTS];
    logic [31:0] r_delay  [EVENT_SLOTS];
    logic [31:0] r_param  [EVENT_SLOTS];
    logic [TICK_W-1:0] r_tick;
    t_opcode     r_op;
    logic [31:0] r_dms, r_h, r_p, r_id, r_d;
    logic [CW-1:0] r_idx;
    logic        r_hit_found, r_free_found;
    logic [IW-1:0] r_hit, r_free;
    t_result     r_res;
    logic        r_ovalid;
    logic        w_conv_done;
    logic [31:0] w_ticks;
    logic [IW-1:0] w_i, w_sel, w_cid;
    logic        w_occ, w_id_ok;
    logic        w_rearm, w_create_ok, w_ok;
    logic [31:0] w_new_id, w_oid;
    logic        w_emit, w_out;

    ett_conv #(.TICK_PERIOD_US(TICK_PERIOD_US)) u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_IDLE && i_valid
                 && (i_opcode == OP_CREATE_UNIQUE || i_opcode == OP_CREATE_NEW)),
        .i_ms(i_delay_ms), .o_done(w_conv_done), .o_ticks(w_ticks)
    );

    assign w_i   = r_idx[IW-1:0];
    assign w_occ = r_used[w_i] && (r_handle[w_i] != 32'd0);
    assign w_cid = r_id[IW-1:0];
    assign w_id_ok = ((r_id & ID_SLOT_MASK) < 32'(EVENT_SLOTS)) && r_used[w_cid]
                     && (r_ident[w_cid] == r_id) && (r_handle[w_cid] != 32'd0);
    assign w_rearm = (r_op == OP_CREATE_UNIQUE) && r_hit_found;
    assign w_sel = w_rearm ? r_hit : r_free;
    assign w_create_ok = (r_h != 32'd0) && (w_rearm || r_free_found);
    assign w_new_id = {r_tick, 12'(w_sel)};
    assign w_oid = (r_op == OP_CREATE_NEW && w_create_ok) ? w_new_id : 32'd0;
    assign w_ok = (r_op == OP_CREATE_UNIQUE || r_op == OP_CREATE_NEW) ? w_create_ok
                : (r_op == OP_CLEAN_HANDLE) ? (r_h != 32'd0 && r_hit_found)
                : (r_op == OP_SEARCH_ID || r_op == OP_RESET_ID
                   || r_op == OP_CLEAN_ID) ? w_id_ok
                : 1'b1;
    assign w_emit = (r_state == S_EMIT);
    assign w_out  = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_tick   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= t_opcode'(i_opcode);
                        r_dms <= i_delay_ms;
                        r_h <= i_handle;
                        r_p <= i_user_param;
                        r_id <= i_event_id;
                        r_idx <= '0;
                        r_hit_found <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state <= (i_opcode == OP_CREATE_UNIQUE
                                    || i_opcode == OP_CREATE_NEW) ? S_CONV : S_SCAN;
                    end
                end
                S_CONV: begin
                    if (w_conv_done) begin
                        r_d <= w_ticks;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_used[w_i] || r_handle[w_i] == 32'd0) begin
                        if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free <= w_i;
                        end
                    end else if (r_handle[w_i] == r_h && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                        r_hit <= w_i;
                    end
                    if (r_op == OP_TICK && w_occ && r_delay[w_i] != 32'd0)
                        r_delay[w_i] <= r_delay[w_i] - 32'd1;
                    if (r_op == OP_DISPATCH && w_occ && r_delay[w_i] == 32'd0) begin
                        r_res <= '{ok: 1'b1, fired: 1'b1, id: r_ident[w_i],
                                   handle: r_handle[w_i], param: r_param[w_i], last: 1'b0};
                        r_ovalid <= 1'b1;
                        r_used[w_i] <= 1'b0;
                        r_state <= S_EMIT;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_idx == LAST_IDX) r_state <= S_APPLY;
                        else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_APPLY: begin
                    r_res <= '{ok: w_ok, fired: 1'b0, id: w_oid, handle: 32'd0,
                               param: 32'd0, last: 1'b1};
                    r_ovalid <= 1'b1;
                    r_state <= S_OUT;
                    unique case (r_op)
                        OP_CREATE_UNIQUE, OP_CREATE_NEW: begin
                            if (w_create_ok) begin
                                r_delay[w_sel] <= r_d;
                                r_param[w_sel] <= r_p;
                                if (!w_rearm) begin
                                    r_used[w_sel] <= 1'b1;
                                    r_handle[w_sel] <= r_h;
                                    r_ident[w_sel] <= w_new_id;
                                end
                            end
                        end
                        OP_CLEAN_HANDLE: begin
                            if (w_ok) r_used[r_hit] <= 1'b0;
                        end
                        OP_RESET_ID: begin
                            if (w_id_ok) r_delay[w_cid] <= r_dms;
                        end
                        OP_CLEAN_ID: begin
                            if (w_id_ok) r_used[w_cid] <= 1'b0;
                        end
                        OP_TICK: begin
                            r_tick <= r_tick + TICK_W'(1);
                        end
                        OP_SEARCH_ID, OP_DISPATCH: begin
                        end
                    endcase
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_ok         = r_res.ok;
    assign o_fired      = r_res.fired;
    assign o_out_id     = r_res.id;
    assign o_out_handle = r_res.handle;
    assign o_out_param  = r_res.param;
    assign o_last       = r_res.last;

    `include "event_timer_table_top_macros.svh"
    `ETT_ASSERT_IMP(a_valid_state, i_clk, i_rst_n, r_ovalid, w_emit || w_out, "valid outside output")
    `ETT_ASSERT_IMP(a_emit_fired, i_clk, i_rst_n, w_emit, r_res.fired && !r_res.last, "emit not fired")
    `ETT_ASSERT_IMP(a_out_last, i_clk, i_rst_n, w_out, r_res.last && !r_res.fired, "close not last")
    `ETT_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, w_out && !i_stall, r_state == S_IDLE, "no idle")
endmodule

// File: hdl/ett_conv.sv
`timescale 1ns / 1ps
module ett_conv #(
    parameter int unsigned TICK_PERIOD_US = ett_pkg::TICK_PERIOD_US_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_ms,
    output logic        o_done,
    output logic [31:0] o_ticks
);
    import ett_pkg::*;

    localparam int unsigned DIVISOR = (TICK_PERIOD_US > 1000) ? TICK_PERIOD_US / 1000 : 1;
    localparam int unsigned FACTOR  = (TICK_PERIOD_US < 1000) ? 1000 / TICK_PERIOD_US : 1;
    localparam int unsigned SHIFT   = $clog2(DIVISOR);
    localparam logic [63:0] RECIP   = ((64'd1 << (32 + SHIFT)) / 64'(DIVISOR)) + 64'd1;
    localparam logic [16:0] RECIP_LO = RECIP[16:0];
    localparam logic [16:0] RECIP_HI = {1'b0, RECIP[32:17]};
    localparam logic [31:0] FAC32   = 32'(FACTOR);

    logic        r_busy;
    logic [31:0] r_num;
    logic [64:0] r_acc;
    logic [31:0] r_res;
    logic        r_done;
    logic [31:0] w_mul_a;
    logic [16:0] w_mul_b;
    logic [48:0] w_prod;
    logic [64:0] w_sum;
    logic [31:0] w_quo;
    logic [31:0] w_plain;

    assign w_mul_a = r_busy ? r_num : i_ms;
    assign w_mul_b = r_busy ? RECIP_HI : RECIP_LO;
    assign w_prod  = 49'(w_mul_a) * 49'(w_mul_b);
    assign w_sum   = r_acc + {w_prod[47:0], 17'd0};
    assign w_quo   = 32'(w_sum >> (32 + SHIFT));
    assign w_plain = (TICK_PERIOD_US == 1000) ? i_ms : 32'(i_ms * FAC32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_start ? (TICK_PERIOD_US <= 1000) : r_busy;
            if (i_start) begin
                if (TICK_PERIOD_US > 1000) begin
                    r_busy <= 1'b1;
                    r_num  <= i_ms;
                    r_acc  <= 65'(w_prod);
                end else begin
                    r_res  <= (w_plain == 32'd1) ? 32'd2 : w_plain;
                end
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_res  <= (w_quo == 32'd1) ? 32'd2 : w_quo;
            end
        end
    end

    assign o_done  = r_done;
    assign o_ticks = r_res;

    `include "event_timer_table_top_macros.svh"
    `ETT_ASSERT_NEXT(a_conv_start, i_clk, i_rst_n, i_start, r_busy || r_done, "conversion lost")
    `ETT_ASSERT_NEXT(a_conv_busy, i_clk, i_rst_n, r_busy, r_done && !r_busy, "conversion late")
    `ETT_ASSERT_IMP(a_conv_res, i_clk, i_rst_n, r_done, r_res != 32'd1, "one not promoted")
endmodule
